>>> rtl/rfb_pixel_to_argb_top_assert.svh
// Assertion macros for the RFB pixel to ARGB converter.
// Used by rfb_pixel_to_argb_top; needs clk and rst_n in the including scope.
`ifndef RFB_PIXEL_TO_ARGB_TOP_ASSERT_SVH
`define RFB_PIXEL_TO_ARGB_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RFB_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfb_pixel_to_argb: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfb_pixel_to_argb: next-cycle check failed");

`endif

>>> rtl/rfb_p2a_pkg.sv
// Package for the RFB pixel to ARGB converter: constants, register codes,
// divider step type and helper functions. No dependencies.
package rfb_p2a_pkg;

    localparam int unsigned NUM_STAGES = 6;
    localparam int unsigned NUM_CHAN   = 3;
    localparam int unsigned DIV_STAGES = 4;
    localparam int unsigned MAX_BYTES  = 4;
    localparam int unsigned ADDR_W     = 5;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // channel order inside per-channel arrays
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    // register indexes (word address paddr[4:2])
    localparam logic [2:0] REG_BITS_PER_PIXEL = 3'd0;
    localparam logic [2:0] REG_BIG_ENDIAN     = 3'd1;
    localparam logic [2:0] REG_RED_MAX        = 3'd2;
    localparam logic [2:0] REG_GREEN_MAX      = 3'd3;
    localparam logic [2:0] REG_BLUE_MAX       = 3'd4;
    localparam logic [2:0] REG_RED_SHIFT      = 3'd5;
    localparam logic [2:0] REG_GREEN_SHIFT    = 3'd6;
    localparam logic [2:0] REG_BLUE_SHIFT     = 3'd7;

    // partial remainder and quotient of one channel's value*255/max
    typedef struct packed {
        logic [23:0] rem;
        logic [7:0]  quo;
    } div_t;

    // value * 255 as (value << 8) - value
    function automatic logic [23:0] times_full(logic [15:0] v);
        return {v, 8'd0} - {8'd0, v};
    endfunction

    // one restoring step: try max << pos against the remainder
    function automatic div_t div_step(div_t s, logic [15:0] dsor, logic [2:0] pos);
        div_t        r;
        logic [23:0] d;
        r = s;
        d = {8'd0, dsor} << pos;
        if (s.rem >= d)
        begin
            r.rem      = s.rem - d;
            r.quo[pos] = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> rtl/rfb_pixel_to_argb_top.sv
// RFB true-colour pixel to opaque ARGB8888 converter, top level.
// Depends on rfb_p2a_pkg and rfb_pixel_to_argb_top_assert.svh.
//
// Usage:
//   pix channel  : pix_valid/pix_ready with pixel_bytes, byte k of the pixel
//                  in bits 8k+7..8k. A transfer happens when both are high.
//   argb channel : argb_valid/argb_ready with argb and format_error.
//   APB port     : eight 32-bit registers at 4*index, pready tied high,
//                  reads return the register value. Write only while idle.
// Pipeline: six register stages. Stage 1 assembles the raw word and masks
// each channel, stage 2 forms value*255, stages 3-6 run a restoring divide
// by the channel max, two quotient bits per stage, stage 6 also packs the
// word. argb_valid is the valid bit of stage 6; one pixel per cycle is
// sustained while argb_ready stays high.
// Stall: each stage holds while the next is full and stalled; empty stages
// keep filling, so pix_ready only drops once all six stages hold data.
// Reset: all valid bits clear and registers return to 32 bpp, little
// endian, 8:8:8 at shifts 16/8/0.
// Format error (bpp/8 of zero or above four) gives argb 0, format_error 1.
module rfb_pixel_to_argb_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel input
    input  logic                            pix_valid,
    output logic                            pix_ready,
    input  logic [31:0]                     pixel_bytes,
    // argb output
    output logic                            argb_valid,
    input  logic                            argb_ready,
    output logic [31:0]                     argb,
    output logic                            format_error,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfb_p2a_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int unsigned NS = rfb_p2a_pkg::NUM_STAGES;
    localparam int unsigned NC = rfb_p2a_pkg::NUM_CHAN;
    localparam int unsigned ND = rfb_p2a_pkg::DIV_STAGES;

    // ---------------- configuration registers ----------------
    logic [7:0]  bpp_reg;
    logic        big_endian_reg;
    logic [15:0] max_reg   [NC];
    logic [4:0]  shift_reg [NC];
    logic [2:0]  reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg                         <= 8'd32;
            big_endian_reg                  <= 1'b0;
            max_reg[rfb_p2a_pkg::CH_RED]    <= 16'd255;
            max_reg[rfb_p2a_pkg::CH_GREEN]  <= 16'd255;
            max_reg[rfb_p2a_pkg::CH_BLUE]   <= 16'd255;
            shift_reg[rfb_p2a_pkg::CH_RED]  <= 5'd16;
            shift_reg[rfb_p2a_pkg::CH_GREEN]<= 5'd8;
            shift_reg[rfb_p2a_pkg::CH_BLUE] <= 5'd0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                rfb_p2a_pkg::REG_BITS_PER_PIXEL: bpp_reg        <= pwdata[7:0];
                rfb_p2a_pkg::REG_BIG_ENDIAN:     big_endian_reg <= pwdata[0];
                rfb_p2a_pkg::REG_RED_MAX:
                    max_reg[rfb_p2a_pkg::CH_RED] <= pwdata[15:0];
                rfb_p2a_pkg::REG_GREEN_MAX:
                    max_reg[rfb_p2a_pkg::CH_GREEN] <= pwdata[15:0];
                rfb_p2a_pkg::REG_BLUE_MAX:
                    max_reg[rfb_p2a_pkg::CH_BLUE] <= pwdata[15:0];
                rfb_p2a_pkg::REG_RED_SHIFT:
                    shift_reg[rfb_p2a_pkg::CH_RED] <= pwdata[4:0];
                rfb_p2a_pkg::REG_GREEN_SHIFT:
                    shift_reg[rfb_p2a_pkg::CH_GREEN] <= pwdata[4:0];
                rfb_p2a_pkg::REG_BLUE_SHIFT:
                    shift_reg[rfb_p2a_pkg::CH_BLUE] <= pwdata[4:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rfb_p2a_pkg::REG_BITS_PER_PIXEL: prdata = {24'd0, bpp_reg};
            rfb_p2a_pkg::REG_BIG_ENDIAN:     prdata = {31'd0, big_endian_reg};
            rfb_p2a_pkg::REG_RED_MAX:
                prdata = {16'd0, max_reg[rfb_p2a_pkg::CH_RED]};
            rfb_p2a_pkg::REG_GREEN_MAX:
                prdata = {16'd0, max_reg[rfb_p2a_pkg::CH_GREEN]};
            rfb_p2a_pkg::REG_BLUE_MAX:
                prdata = {16'd0, max_reg[rfb_p2a_pkg::CH_BLUE]};
            rfb_p2a_pkg::REG_RED_SHIFT:
                prdata = {27'd0, shift_reg[rfb_p2a_pkg::CH_RED]};
            rfb_p2a_pkg::REG_GREEN_SHIFT:
                prdata = {27'd0, shift_reg[rfb_p2a_pkg::CH_GREEN]};
            rfb_p2a_pkg::REG_BLUE_SHIFT:
                prdata = {27'd0, shift_reg[rfb_p2a_pkg::CH_BLUE]};
        endcase
    end

    // ---------------- pipeline control ----------------
    // Per-stage ready lets bubbles collapse behind a stalled output.
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] err_reg;
    logic [NS-1:0] err_next;
    logic [NS-1:0] stg_rdy;
    logic [NS-1:0] stg_in;

    always_comb
    begin
        stg_rdy[NS-1] = ~vld_reg[NS-1] | argb_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stg_rdy[k] = ~vld_reg[k] | stg_rdy[k+1];
        end
        stg_in[0] = pix_valid;
        for (int k = 1; k < NS; k++)
        begin
            stg_in[k] = vld_reg[k-1];
        end
        for (int k = 0; k < NS; k++)
        begin
            vld_next[k] = stg_rdy[k] ? stg_in[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pix_ready = stg_rdy[0];

    // ---------------- stage 1: byte assembly, shift and mask ----------------
    logic [4:0]  byte_cnt;
    logic        fmt_bad;
    logic [31:0] raw;
    logic [31:0] shifted [NC];
    logic [15:0] val_reg  [NC];
    logic [15:0] val_next [NC];

    assign byte_cnt = bpp_reg[7:3];
    assign fmt_bad  = (byte_cnt == 5'd0) || (byte_cnt > 5'(rfb_p2a_pkg::MAX_BYTES));

    always_comb
    begin
        unique case (byte_cnt[2:0])
            3'd1: raw = {24'd0, pixel_bytes[7:0]};
            3'd2: raw = big_endian_reg ?
                        {16'd0, pixel_bytes[7:0], pixel_bytes[15:8]} :
                        {16'd0, pixel_bytes[15:0]};
            3'd3: raw = big_endian_reg ?
                        {8'd0, pixel_bytes[7:0], pixel_bytes[15:8], pixel_bytes[23:16]} :
                        {8'd0, pixel_bytes[23:0]};
            3'd4: raw = big_endian_reg ?
                        {pixel_bytes[7:0], pixel_bytes[15:8],
                         pixel_bytes[23:16], pixel_bytes[31:24]} :
                        pixel_bytes;
            default: raw = 32'd0;  // bad byte count, flagged separately
        endcase
        for (int c = 0; c < NC; c++)
        begin
            shifted[c]  = raw >> shift_reg[c];
            val_next[c] = shifted[c][15:0] & max_reg[c];
        end
    end

    // ---------------- stage 2: value * 255 ----------------
    rfb_p2a_pkg::div_t div_reg  [ND][NC];
    rfb_p2a_pkg::div_t div_next [ND][NC];
    rfb_p2a_pkg::div_t fin_div  [NC];
    logic [7:0]        quo_fin  [NC];
    logic [31:0]       argb_reg;
    logic [31:0]       argb_next;

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            div_next[0][c].rem = rfb_p2a_pkg::times_full(val_reg[c]);
            div_next[0][c].quo = 8'd0;
        end
        // stages 3-5: quotient bits 7..2, two per stage
        for (int s = 1; s < ND; s++)
        begin
            for (int c = 0; c < NC; c++)
            begin
                div_next[s][c] = rfb_p2a_pkg::div_step(
                    rfb_p2a_pkg::div_step(div_reg[s-1][c], max_reg[c],
                                          3'(2 * (ND - s) + 1)),
                    max_reg[c], 3'(2 * (ND - s)));
            end
        end
        // stage 6: bits 1..0, zero max forces zero, pack
        for (int c = 0; c < NC; c++)
        begin
            fin_div[c] = rfb_p2a_pkg::div_step(
                rfb_p2a_pkg::div_step(div_reg[ND-1][c], max_reg[c], 3'd1),
                max_reg[c], 3'd0);
            quo_fin[c] = fin_div[c].quo;
            if (max_reg[c] == 16'd0)
            begin
                quo_fin[c] = 8'd0;
            end
        end
        if (err_reg[NS-2])
        begin
            argb_next = 32'd0;
        end
        else
        begin
            argb_next = {rfb_p2a_pkg::ALPHA_OPAQUE,
                         quo_fin[rfb_p2a_pkg::CH_RED],
                         quo_fin[rfb_p2a_pkg::CH_GREEN],
                         quo_fin[rfb_p2a_pkg::CH_BLUE]};
        end
        err_next[0] = fmt_bad;
        for (int k = 1; k < NS; k++)
        begin
            err_next[k] = err_reg[k-1];
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (stg_rdy[k])
            begin
                err_reg[k] <= err_next[k];
            end
        end
        if (stg_rdy[0])
        begin
            val_reg <= val_next;
        end
        for (int s = 0; s < ND; s++)
        begin
            if (stg_rdy[s+1])
            begin
                div_reg[s] <= div_next[s];
            end
        end
        if (stg_rdy[NS-1])
        begin
            argb_reg <= argb_next;
        end
    end

    assign argb_valid   = vld_reg[NS-1];
    assign argb         = argb_reg;
    assign format_error = err_reg[NS-1];

    // ---------------- assertions ----------------
`include "rfb_pixel_to_argb_top_assert.svh"

    `RFB_ASSERT_IMPLY(a_err_zero, argb_valid && format_error, argb == 32'd0)
    `RFB_ASSERT_IMPLY(a_alpha_opaque, argb_valid && !format_error, argb[31:24] == rfb_p2a_pkg::ALPHA_OPAQUE)
    `RFB_ASSERT_IMPLY(a_full_blocks, (&vld_reg) && !argb_ready, !pix_ready)
    `RFB_ASSERT_NEXT(a_take_moves, pix_valid && pix_ready, vld_reg[0])

endmodule
